### src/tbbeq_pkg.sv
// shared types and constants for the three-band biquad equalizer
package tbbeq_pkg;

  // fixed point and register map
  localparam int COEF_FRAC       = 16;
  localparam int AUDIO_WIDTH     = 16;
  localparam int BAND_SLOTS      = 3;
  localparam int CFG_INDEX_WIDTH = 3;

  localparam logic [CFG_INDEX_WIDTH-1:0] REG_BASS_FF   = 3'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_BASS_FB   = 3'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_MID_FF    = 3'd2;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_MID_FB    = 3'd3;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_TREBLE_FF = 3'd4;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_TREBLE_FB = 3'd5;

  // one input request
  typedef struct packed {
    logic signed [AUDIO_WIDTH-1:0] sample_in;
    logic                          first_of_buffer;
  } eq_req_t;

  // one result
  typedef struct packed {
    logic signed [AUDIO_WIDTH-1:0] sample_out;
    logic                          clipped;
  } eq_rsp_t;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_MAC    = 4'b0010,
    ST_SAT    = 4'b0100,
    ST_FINISH = 4'b1000
  } eq_state_t;

endpackage

### src/three_band_biquad_equalizer_unit.sv
// three-band direct form 1 biquad equalizer with one shared multiply-accumulate unit
//
// Usage: audio samples arrive on the req channel (req_valid / req_stall, payload req_data
// with sample_in and first_of_buffer); results leave on the rsp channel (rsp_valid /
// rsp_stall, payload rsp_data with sample_out and clipped). One result per request.
// Coefficients are written through cfg_write / cfg_index / cfg_data while the block idles;
// the user must keep to this, as the block itself does not enforce it. Writes to an index
// past the last register are dropped.
// Timing: one signed multiplier and one accumulator serve all products. Each band runs its
// five products in ST_MAC and then rounds and saturates in ST_SAT; ST_FINISH then loads the
// result register, and the next request is taken once the sequencer is back in ST_IDLE.
// req_stall is high while a sample is being filtered. A finished result sits in the
// output register; a new request is taken while it waits, and the next result is held
// back in the sequencer until the receiver drops rsp_stall.
// Reset (rst, synchronous): history cleared, coefficients back to pass-through
// (b0 = 1.0, all others zero), no result pending.
// first_of_buffer clears all band history before that sample is filtered.
module three_band_biquad_equalizer_unit #(
  parameter int BAND_COUNT   = 3,
  parameter int COEF_WIDTH   = 20,
  parameter int SAMPLE_WIDTH = 24
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    req_valid,
  output logic                                    req_stall,
  input  tbbeq_pkg::eq_req_t                      req_data,
  output logic                                    rsp_valid,
  input  logic                                    rsp_stall,
  output tbbeq_pkg::eq_rsp_t                      rsp_data,
  input  logic                                    cfg_write,
  input  logic [tbbeq_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
  input  logic [3*COEF_WIDTH-1:0]                 cfg_data
);
  import tbbeq_pkg::*;

  localparam int CW     = COEF_WIDTH;
  localparam int SW     = SAMPLE_WIDTH;
  localparam int PW     = CW + SW;
  localparam int AW     = PW + 3;
  localparam int SHW    = AW - COEF_FRAC;
  localparam int BAND_W = (BAND_COUNT > 1) ? $clog2(BAND_COUNT) : 1;
  localparam logic signed [AW-1:0] ROUND_BIAS = AW'(1 << (COEF_FRAC - 1));
  localparam logic [BAND_W-1:0]    LAST_BAND  = BAND_W'(BAND_COUNT - 1);

  localparam logic [2:0] TERM_B0 = 3'd0;
  localparam logic [2:0] TERM_B1 = 3'd1;
  localparam logic [2:0] TERM_B2 = 3'd2;
  localparam logic [2:0] TERM_A1 = 3'd3;
  localparam logic [2:0] TERM_A2 = 3'd4;

  typedef struct packed {
    logic signed [SW-1:0] d1;
    logic signed [SW-1:0] d2;
  } hist_t;

  eq_state_t             state;
  logic [BAND_W-1:0]     band;
  logic [2:0]            term;
  logic signed [SW-1:0]  x_cur;
  logic signed [PW-1:0]  prod;
  logic                  prod_sub;
  logic signed [AW-1:0]  acc;
  logic                  clip;
  hist_t                 hist_x [BAND_COUNT];
  hist_t                 hist_y [BAND_COUNT];
  logic [3*CW-1:0]       cfg_ff [BAND_SLOTS];
  logic [2*CW-1:0]       cfg_fb [BAND_SLOTS];

  logic [1:0]            cfg_slot;
  logic [3*CW-1:0]       ff_sel;
  logic [2*CW-1:0]       fb_sel;
  logic signed [CW-1:0]  coef_op;
  logic signed [SW-1:0]  data_op;
  logic signed [PW-1:0]  prod_next;
  logic signed [AW-1:0]  prod_ext;
  logic signed [AW-1:0]  acc_next;
  logic [SHW-1:0]        shifted;
  logic [SHW-SW:0]       sec_upper;
  logic                  sec_ovf;
  logic signed [SW-1:0]  y_sec;
  logic [SW-AUDIO_WIDTH:0] fin_upper;
  logic                  fin_ovf;
  logic signed [AUDIO_WIDTH-1:0] y_fin;
  logic                  req_take;
  logic                  rsp_free;

  assign req_stall = (state != ST_IDLE);
  assign req_take  = req_valid && !req_stall;
  assign rsp_free  = !rsp_valid || !rsp_stall;

  // coefficient and operand select for the current band and term
  assign cfg_slot = 2'(band);
  assign ff_sel   = cfg_ff[cfg_slot];
  assign fb_sel   = cfg_fb[cfg_slot];

  always_comb begin
    unique case (term)
      TERM_B0: begin
        coef_op = $signed(ff_sel[0*CW +: CW]);
        data_op = x_cur;
      end
      TERM_B1: begin
        coef_op = $signed(ff_sel[1*CW +: CW]);
        data_op = hist_x[band].d1;
      end
      TERM_B2: begin
        coef_op = $signed(ff_sel[2*CW +: CW]);
        data_op = hist_x[band].d2;
      end
      TERM_A1: begin
        coef_op = $signed(fb_sel[0*CW +: CW]);
        data_op = hist_y[band].d1;
      end
      TERM_A2: begin
        coef_op = $signed(fb_sel[1*CW +: CW]);
        data_op = hist_y[band].d2;
      end
      default: begin
        coef_op = '0;
        data_op = '0;
      end
    endcase
  end

  // shared multiplier and accumulator
  assign prod_next = coef_op * data_op;
  assign prod_ext  = {{(AW-PW){prod[PW-1]}}, prod};
  assign acc_next  = prod_sub ? (acc - prod_ext) : (acc + prod_ext);

  // round (bias already in acc), floor shift, saturate to the section width
  assign shifted   = acc_next[AW-1:COEF_FRAC];
  assign sec_upper = shifted[SHW-1:SW-1];
  assign sec_ovf   = !((&sec_upper) || !(|sec_upper));
  assign y_sec     = sec_ovf ? {shifted[SHW-1], {(SW-1){~shifted[SHW-1]}}}
                             : $signed(shifted[SW-1:0]);

  // final saturation to the audio width
  assign fin_upper = x_cur[SW-1:AUDIO_WIDTH-1];
  assign fin_ovf   = !((&fin_upper) || !(|fin_upper));
  assign y_fin     = fin_ovf ? {x_cur[SW-1], {(AUDIO_WIDTH-1){~x_cur[SW-1]}}}
                             : $signed(x_cur[AUDIO_WIDTH-1:0]);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < BAND_SLOTS; i++) begin
        cfg_ff[i] <= (3*CW)'(65536);
        cfg_fb[i] <= '0;
      end
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_BASS_FF:   cfg_ff[0] <= cfg_data;
        REG_BASS_FB:   cfg_fb[0] <= cfg_data[2*CW-1:0];
        REG_MID_FF:    cfg_ff[1] <= cfg_data;
        REG_MID_FB:    cfg_fb[1] <= cfg_data[2*CW-1:0];
        REG_TREBLE_FF: cfg_ff[2] <= cfg_data;
        REG_TREBLE_FB: cfg_fb[2] <= cfg_data[2*CW-1:0];
        default: ;
      endcase
    end
  end

  // sequencer, history and control
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      band      <= '0;
      term      <= TERM_B0;
      rsp_valid <= 1'b0;
      for (int i = 0; i < BAND_COUNT; i++) begin
        hist_x[i] <= '0;
        hist_y[i] <= '0;
      end
    end else begin
      // result taken with no new one to load
      if (rsp_valid && !rsp_stall && (state != ST_FINISH)) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (req_take) begin
            state <= ST_MAC;
            band  <= '0;
            term  <= TERM_B0;
            if (req_data.first_of_buffer) begin
              for (int i = 0; i < BAND_COUNT; i++) begin
                hist_x[i] <= '0;
                hist_y[i] <= '0;
              end
            end
          end
        end
        ST_MAC: begin
          if (term == TERM_A2) begin
            state <= ST_SAT;
          end else begin
            term <= term + 3'd1;
          end
        end
        ST_SAT: begin
          hist_x[band] <= '{d1: x_cur, d2: hist_x[band].d1};
          hist_y[band] <= '{d1: y_sec, d2: hist_y[band].d1};
          term         <= TERM_B0;
          if (band == LAST_BAND) begin
            state <= ST_FINISH;
          end else begin
            band  <= band + BAND_W'(1);
            state <= ST_MAC;
          end
        end
        ST_FINISH: begin
          if (rsp_free) begin
            rsp_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        x_cur <= SW'($signed(req_data.sample_in));
        acc   <= ROUND_BIAS;
        clip  <= 1'b0;
      end
      ST_MAC: begin
        prod     <= prod_next;
        prod_sub <= (term == TERM_A1) || (term == TERM_A2);
        if (term != TERM_B0) begin
          acc <= acc_next;
        end
      end
      ST_SAT: begin
        x_cur <= y_sec;
        acc   <= ROUND_BIAS;
        clip  <= clip | sec_ovf;
      end
      ST_FINISH: begin
        if (rsp_free) begin
          rsp_data.sample_out <= y_fin;
          rsp_data.clipped    <= clip | fin_ovf;
        end
      end
      default: ;
    endcase
  end

endmodule
